// File: design/trpp_pkg.sv
// Shared types, constants and helper functions for the trochoid pen point generator.
package trpp_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS      = 16;
  localparam int MAX_TURNS      = 512;
  localparam int CORDIC_STAGES_DEF = 18;

  // Per-item divider: 37 integer quotient bits, then FRAC_BITS fraction bits
  localparam int INT_STEPS  = 37;
  localparam int QUO_W      = INT_STEPS + FRAC_BITS;
  localparam int SIDE_W     = 33;

  // CORDIC datapath width and gain-compensated start value (Q30)
  localparam int ZW = 34;
  localparam logic signed [ZW-1:0] GAIN_Q30 = 34'sd652032874;

  // Register reset values
  localparam logic [9:0]  RING_RST  = 10'd96;
  localparam logic [9:0]  WHEEL_RST = 10'd32;
  localparam logic        MESH_RST  = 1'b0;
  localparam logic [17:0] PENF_RST  = 18'd49152;

  // Register indexes
  localparam logic [1:0] REG_RING  = 2'd0;
  localparam logic [1:0] REG_WHEEL = 2'd1;
  localparam logic [1:0] REG_MESH  = 2'd2;
  localparam logic [1:0] REG_PENF  = 2'd3;

  typedef enum logic [2:0] {
    GS_IDLE,
    GS_START,
    GS_ORBIT,
    GS_PEN,
    GS_GCD,
    GS_LOBE,
    GS_TURN
  } geo_state_e;

  // Geometry derived from the configuration, held between writes
  typedef struct packed {
    logic               busy;
    logic               outside;
    logic [9:0]         n_teeth;
    logic [8:0]         half_n;
    logic signed [11:0] spin;
    logic signed [26:0] orbit_q;
    logic [24:0]        pen_q;
    logic [25:0]        outer;
    logic [25:0]        inner;
    logic [9:0]         lobes;
    logic [9:0]         turns;
    logic               usable;
  } geom_t;

  // Arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turns(input int unsigned i);
    logic [31:0] a;
    case (i)
      0:  a = 32'h20000000;  1:  a = 32'h12E4051E;  2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;  4:  a = 32'h028B0D43;  5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;  7:  a = 32'h00517C55;  8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;  10: a = 32'h000A2F98;  11: a = 32'h000517CC;
      12: a = 32'h00028BE6;  13: a = 32'h000145F3;  14: a = 32'h0000A2F9;
      15: a = 32'h0000517C;  16: a = 32'h000028BE;  17: a = 32'h0000145F;
      18: a = 32'h00000A2F;  19: a = 32'h00000517;  20: a = 32'h0000028B;
      21: a = 32'h00000145;  22: a = 32'h000000A2;  23: a = 32'h00000051;
      24: a = 32'h00000028;  25: a = 32'h00000014;  26: a = 32'h0000000A;
      27: a = 32'h00000005;  28: a = 32'h00000002;  29: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

  // Fold a phase into +-quarter turn; returns {negate, z}
  function automatic logic [ZW:0] fold_phase(input logic [31:0] ph);
    logic signed [ZW-1:0] zs;
    logic                 neg;
    zs  = $signed({{(ZW-32){ph[31]}}, ph});
    neg = 1'b0;
    if (zs > 34'sd1073741824) begin
      zs  = zs - 34'sd2147483648;
      neg = 1'b1;
    end else if (zs < -34'sd1073741824) begin
      zs  = zs + 34'sd2147483648;
      neg = 1'b1;
    end
    return {neg, zs};
  endfunction

  // Round a Q46 product sum (Q16 times Q30) to Q16 and saturate to 27 bits
  function automatic logic [26:0] round_sat27(input logic signed [61:0] v);
    logic signed [61:0] r;
    r = (v + 62'sd536870912) >>> 30;
    if (r > 62'sd67108863)
      return 27'h3FFFFFF;
    else if (r < -62'sd67108864)
      return 27'h4000000;
    else
      return r[26:0];
  endfunction

endpackage

// File: design/trochoid_pen_point_top.sv
// Trochoid pen point generator: top level with config port, divider chain and CORDIC chains.
// Throughput: one transaction per cycle; all stages advance together, held while the
// output register is stalled.
// After reset and after every config write the geometry sequencer (shared serial divider
// and subtractive gcd) runs, during which input is stalled.
// Reset clears control state and loads the register defaults.
module trochoid_pen_point_top #(
  parameter int CORDIC_STAGES = trpp_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic signed [25:0] orbit_angle_i,
  input  logic signed [15:0] slip_teeth_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [26:0] pen_x_o,
  output logic signed [26:0] pen_y_o,
  output logic signed [39:0] wheel_angle_o,
  output logic [25:0] outer_radius_o,
  output logic [25:0] inner_radius_o,
  output logic [9:0]  lobes_o,
  output logic [9:0]  turns_to_close_o,
  output logic        usable_o
);
  import trpp_pkg::*;

  geom_t geom;
  logic  en, accept;

  // Config port
  assign pready = 1'b1;

  trpp_geom u_geom (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (psel & penable & pwrite),
    .wr_idx_i  (paddr[3:2]),
    .wr_data_i (pwdata),
    .rd_idx_i  (paddr[3:2]),
    .rd_data_o (prdata),
    .geom_o    (geom)
  );

  // Global advance: hold everything while a result waits
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en || geom.busy;
  assign accept     = in_valid_i && !in_stall_o;

  // Stage 1: spin numerator
  logic               v1_q;
  logic signed [37:0] m_q;
  logic [31:0]        pho1_q;
  // Stage 2: biased dividend
  logic               v2_q;
  logic [45:0]        dvd2_q;
  logic [31:0]        pho2_q;
  logic signed [47:0] dvd_full;

  assign dvd_full = 48'(m_q) + $signed({2'b0, geom.n_teeth, 36'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= accept;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q    <= 38'(orbit_angle_i) * 38'(geom.spin) + (38'(slip_teeth_i) <<< 8);
      pho1_q <= {orbit_angle_i[15:0], 16'b0};
      dvd2_q <= dvd_full[45:0];
      pho2_q <= pho1_q;
    end
  end

  // Divider chain
  logic              dv   [0:QUO_W];
  logic [9:0]        drem [0:QUO_W];
  logic [QUO_W-1:0]  ddvd [0:QUO_W];
  logic [QUO_W-1:0]  dquo [0:QUO_W];
  logic [SIDE_W-1:0] dside[0:QUO_W];

  assign dv[0]    = v2_q;
  assign drem[0]  = {1'b0, dvd2_q[45:INT_STEPS]};
  assign ddvd[0]  = {dvd2_q[INT_STEPS-1:0], {FRAC_BITS{1'b0}}};
  assign dquo[0]  = '0;
  assign dside[0] = {1'b0, pho2_q};

  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    logic [SIDE_W-1:0] side_in;
    logic [10:0]       rsum;
    // Record the rounding decision once the integer remainder is known
    assign rsum = {1'b0, drem[i]} + {2'b0, geom.half_n};
    if (i == INT_STEPS) begin : g_rnd
      assign side_in = {(rsum >= {1'b0, geom.n_teeth}), dside[i][31:0]};
    end else begin : g_pass
      assign side_in = dside[i];
    end
    trpp_div_cell #(.QW(QUO_W), .SW(SIDE_W)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .divisor_i (geom.n_teeth),
      .valid_i   (dv[i]),
      .rem_i     (drem[i]),
      .dvd_i     (ddvd[i]),
      .quo_i     (dquo[i]),
      .side_i    (side_in),
      .valid_o   (dv[i+1]),
      .rem_o     (drem[i+1]),
      .dvd_o     (ddvd[i+1]),
      .quo_o     (dquo[i+1]),
      .side_o    (dside[i+1])
    );
  end

  // Wheel angle and pen phase from the quotient
  logic [39:0] wheel_d;
  logic [31:0] php_d;
  logic [ZW:0] fold_o, fold_p;
  assign wheel_d = {3'b0, dquo[QUO_W][QUO_W-1:FRAC_BITS]} + {39'b0, dside[QUO_W][32]}
                 - 40'h1000000000;
  assign php_d   = dquo[QUO_W][31:0] + {geom.outside, 31'b0};
  assign fold_o  = fold_phase(dside[QUO_W][31:0]);
  assign fold_p  = fold_phase(php_d);

  // CORDIC prep stage
  logic              vp_q;
  logic signed [ZW-1:0] zo_q, zp_q;
  logic              nego_q, negp_q;
  logic [39:0]       wheelp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)
      vp_q <= 1'b0;
    else if (en)
      vp_q <= dv[QUO_W];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      zo_q     <= $signed(fold_o[ZW-1:0]);
      nego_q   <= fold_o[ZW];
      zp_q     <= $signed(fold_p[ZW-1:0]);
      negp_q   <= fold_p[ZW];
      wheelp_q <= wheel_d;
    end
  end

  // Two CORDIC chains: orbit angle and pen angle
  logic                 ov [0:CORDIC_STAGES];
  logic signed [ZW-1:0] ox [0:CORDIC_STAGES];
  logic signed [ZW-1:0] oy [0:CORDIC_STAGES];
  logic signed [ZW-1:0] oz [0:CORDIC_STAGES];
  logic [40:0]          os [0:CORDIC_STAGES];
  logic                 pv [0:CORDIC_STAGES];
  logic signed [ZW-1:0] px [0:CORDIC_STAGES];
  logic signed [ZW-1:0] py [0:CORDIC_STAGES];
  logic signed [ZW-1:0] pz [0:CORDIC_STAGES];
  logic [0:0]           ps [0:CORDIC_STAGES];

  assign ov[0] = vp_q;
  assign ox[0] = GAIN_Q30;
  assign oy[0] = '0;
  assign oz[0] = zo_q;
  assign os[0] = {wheelp_q, nego_q};
  assign pv[0] = vp_q;
  assign px[0] = GAIN_Q30;
  assign py[0] = '0;
  assign pz[0] = zp_q;
  assign ps[0] = negp_q;

  for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cordic
    trpp_cordic_cell #(.STEP(j), .SW(41)) u_orb (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (ov[j]),
      .x_i     (ox[j]),
      .y_i     (oy[j]),
      .z_i     (oz[j]),
      .side_i  (os[j]),
      .valid_o (ov[j+1]),
      .x_o     (ox[j+1]),
      .y_o     (oy[j+1]),
      .z_o     (oz[j+1]),
      .side_o  (os[j+1])
    );
    trpp_cordic_cell #(.STEP(j), .SW(1)) u_pen (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (pv[j]),
      .x_i     (px[j]),
      .y_i     (py[j]),
      .z_i     (pz[j]),
      .side_i  (ps[j]),
      .valid_o (pv[j+1]),
      .x_o     (px[j+1]),
      .y_o     (py[j+1]),
      .z_o     (pz[j+1]),
      .side_o  (ps[j+1])
    );
  end

  // Fix stage: undo the half-turn fold
  logic                 vf_q;
  logic signed [ZW-1:0] c1_q, s1_q, c2_q, s2_q;
  logic [39:0]          wheelf_q;
  // Multiply stage
  logic                 vm_q;
  logic signed [60:0]   xo_q, xp_q, yo_q, yp_q;
  logic [39:0]          wheelm_q;
  // Output register
  logic                 vo_q;
  logic [26:0]          penx_q, peny_q;
  logic [39:0]          wheelo_q;
  logic signed [26:0]   penq_s;

  assign penq_s = $signed({2'b0, geom.pen_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
      vm_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      vf_q <= ov[CORDIC_STAGES];
      vm_q <= vf_q;
      vo_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q     <= os[CORDIC_STAGES][0] ? -ox[CORDIC_STAGES] : ox[CORDIC_STAGES];
      s1_q     <= os[CORDIC_STAGES][0] ? -oy[CORDIC_STAGES] : oy[CORDIC_STAGES];
      c2_q     <= ps[CORDIC_STAGES][0] ? -px[CORDIC_STAGES] : px[CORDIC_STAGES];
      s2_q     <= ps[CORDIC_STAGES][0] ? -py[CORDIC_STAGES] : py[CORDIC_STAGES];
      wheelf_q <= os[CORDIC_STAGES][40:1];
      xo_q     <= 61'(geom.orbit_q) * 61'(c1_q);
      xp_q     <= 61'(penq_s) * 61'(c2_q);
      yo_q     <= 61'(geom.orbit_q) * 61'(s1_q);
      yp_q     <= 61'(penq_s) * 61'(s2_q);
      wheelm_q <= wheelf_q;
      penx_q   <= round_sat27(62'(xo_q) + 62'(xp_q));
      peny_q   <= round_sat27(62'(yo_q) + 62'(yp_q));
      wheelo_q <= wheelm_q;
    end
  end

  // Result ports; the user must keep the geometry constant while transactions are in flight (not enforced here)
  assign out_valid_o      = vo_q;
  assign pen_x_o          = $signed(penx_q);
  assign pen_y_o          = $signed(peny_q);
  assign wheel_angle_o    = $signed(wheelo_q);
  assign outer_radius_o   = geom.outer;
  assign inner_radius_o   = geom.inner;
  assign lobes_o          = geom.lobes;
  assign turns_to_close_o = geom.turns;
  assign usable_o         = geom.usable;

endmodule

// File: design/trpp_serdiv.sv
// Bit-serial restoring divider, one quotient bit per cycle, shared by the geometry setup.
module trpp_serdiv (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [39:0] dividend_i,
  input  logic [9:0]  divisor_i,
  output logic        done_o,
  output logic [39:0] quotient_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [9:0]  rem_q, rem_d;
  logic [9:0]  dsr_q, dsr_d;
  logic [39:0] sh_q, sh_d;
  logic [10:0] trial;
  logic        ge;

  // Shift one dividend bit into the remainder and try the subtract
  assign trial = {rem_q, sh_q[39]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    sh_d   = sh_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      rem_d  = 10'd0;
      dsr_d  = divisor_i;
      sh_d   = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? 10'(trial - {1'b0, dsr_q}) : trial[9:0];
      sh_d  = {sh_q[38:0], ge};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd39) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    sh_q  <= sh_d;
  end

  assign done_o     = done_q;
  assign quotient_o = sh_q;

endmodule

// File: design/trpp_geom.sv
// Configuration registers and the sequencer that derives the train geometry from them.
module trpp_geom (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [1:0]          wr_idx_i,
  input  logic [31:0]         wr_data_i,
  input  logic [1:0]          rd_idx_i,
  output logic [31:0]         rd_data_o,
  output trpp_pkg::geom_t     geom_o
);
  import trpp_pkg::*;

  logic [9:0]  ring_q, wheel_q;
  logic        mesh_q;
  logic [17:0] penf_q;

  geo_state_e  state_q, state_d;

  logic signed [26:0] orbit_r_q;
  logic [24:0] pen_r_q;
  logic [9:0]  ga_q, gb_q, lobes_q, turns_q;

  logic [9:0]  big_n, small_n;
  logic [16:0] pen_p;
  logic signed [11:0] k_val;
  logic        div_start, div_done;
  logic [39:0] div_dvd, div_quo;
  logic [9:0]  div_dsr;
  logic signed [39:0] orbit_dvd;
  logic [39:0] pen_dvd;
  logic [26:0] absorb;
  logic [27:0] outer_sum;
  logic signed [27:0] inner_diff;
  logic [27:0] inner_abs;

  // Raise teeth to three, clamp the pen fraction to 0..1
  assign big_n   = (ring_q  < 10'd3) ? 10'd3 : ring_q;
  assign small_n = (wheel_q < 10'd3) ? 10'd3 : wheel_q;
  always_comb begin
    if (penf_q[17])
      pen_p = 17'd0;
    else if (penf_q[16:0] > 17'd65536)
      pen_p = 17'd65536;
    else
      pen_p = penf_q[16:0];
  end
  assign k_val = mesh_q ? $signed({2'b0, big_n} + {2'b0, small_n})
                        : $signed({2'b0, big_n} - {2'b0, small_n});

  // Biased so the dividend stays positive; the bias is N * 2^26
  assign orbit_dvd = (40'(k_val) <<< FRAC_BITS) + $signed({31'b0, big_n[9:1]})
                   + $signed({4'b0, big_n, 26'b0});
  assign pen_dvd   = 40'(pen_p * small_n) + {31'b0, big_n[9:1]};

  // Config register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q  <= RING_RST;
      wheel_q <= WHEEL_RST;
      mesh_q  <= MESH_RST;
      penf_q  <= PENF_RST;
    end else if (wr_en_i) begin
      case (wr_idx_i)
        REG_RING:  ring_q  <= wr_data_i[9:0];
        REG_WHEEL: wheel_q <= wr_data_i[9:0];
        REG_MESH:  mesh_q  <= wr_data_i[0];
        REG_PENF:  penf_q  <= wr_data_i[17:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (rd_idx_i)
      REG_RING:  rd_data_o = {22'b0, ring_q};
      REG_WHEEL: rd_data_o = {22'b0, wheel_q};
      REG_MESH:  rd_data_o = {31'b0, mesh_q};
      REG_PENF:  rd_data_o = {14'b0, penf_q};
      default:   rd_data_o = 32'd0;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      GS_START: state_d = GS_ORBIT;
      GS_ORBIT: if (div_done) state_d = GS_PEN;
      GS_PEN:   if (div_done) state_d = GS_GCD;
      GS_GCD:   if (ga_q == gb_q) state_d = GS_LOBE;
      GS_LOBE:  if (div_done) state_d = GS_TURN;
      GS_TURN:  if (div_done) state_d = GS_IDLE;
      default:  state_d = GS_IDLE;
    endcase
    if (wr_en_i)
      state_d = GS_START;
  end

  // Divider requests
  always_comb begin
    div_start = 1'b0;
    div_dvd   = 40'd0;
    div_dsr   = big_n;
    case (state_q)
      GS_START: begin
        div_start = 1'b1;
        div_dvd   = orbit_dvd;
      end
      GS_ORBIT: begin
        div_start = div_done;
        div_dvd   = pen_dvd;
      end
      GS_GCD: begin
        div_start = (ga_q == gb_q);
        div_dvd   = {30'b0, big_n};
        div_dsr   = ga_q;
      end
      GS_LOBE: begin
        div_start = div_done;
        div_dvd   = {30'b0, small_n};
        div_dsr   = ga_q;
      end
      default: ;
    endcase
  end

  trpp_serdiv u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)
      state_q <= GS_START;
    else
      state_q <= state_d;
  end

  // Capture division results and run the subtractive gcd
  always_ff @(posedge clk_i) begin
    case (state_q)
      GS_ORBIT: if (div_done) orbit_r_q <= 27'(div_quo[27:0] - 28'h4000000);
      GS_PEN: begin
        if (div_done) begin
          pen_r_q <= div_quo[24:0];
          ga_q    <= big_n;
          gb_q    <= small_n;
        end
      end
      GS_GCD: begin
        if (ga_q > gb_q)
          ga_q <= ga_q - gb_q;
        else if (gb_q > ga_q)
          gb_q <= gb_q - ga_q;
      end
      GS_LOBE: if (div_done) lobes_q <= div_quo[9:0];
      GS_TURN: if (div_done) turns_q <= div_quo[9:0];
      default: ;
    endcase
  end

  // Radii from the orbit and pen lengths
  assign absorb     = orbit_r_q[26] ? 27'(-orbit_r_q) : 27'(orbit_r_q);
  assign outer_sum  = {1'b0, absorb} + {3'b0, pen_r_q};
  assign inner_diff = $signed({1'b0, absorb}) - $signed({3'b0, pen_r_q});
  assign inner_abs  = inner_diff[27] ? 28'(-inner_diff) : 28'(inner_diff);

  always_comb begin
    geom_o.busy    = (state_q != GS_IDLE);
    geom_o.outside = mesh_q;
    geom_o.n_teeth = small_n;
    geom_o.half_n  = small_n[9:1];
    geom_o.spin    = mesh_q ? k_val : -k_val;
    geom_o.orbit_q = orbit_r_q;
    geom_o.pen_q   = pen_r_q;
    geom_o.outer   = (outer_sum > 28'h3FFFFFF) ? 26'h3FFFFFF : outer_sum[25:0];
    geom_o.inner   = (inner_abs > 28'h3FFFFFF) ? 26'h3FFFFFF : inner_abs[25:0];
    geom_o.lobes   = lobes_q;
    geom_o.turns   = turns_q;
    geom_o.usable  = (mesh_q || (small_n < big_n)) && (turns_q <= 10'(MAX_TURNS))
                     && (k_val > 12'sd0);
  end

endmodule

// File: design/trpp_div_cell.sv
// One restoring division cell of the per-item divider chain: one quotient bit per cell.
module trpp_div_cell #(
  parameter int QW = trpp_pkg::QUO_W,
  parameter int SW = trpp_pkg::SIDE_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [9:0]    divisor_i,
  input  logic          valid_i,
  input  logic [9:0]    rem_i,
  input  logic [QW-1:0] dvd_i,
  input  logic [QW-1:0] quo_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [9:0]    rem_o,
  output logic [QW-1:0] dvd_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic [10:0] trial;
  logic        ge;
  logic [9:0]  rem_d;

  // Bring down the next dividend bit and subtract if it fits
  assign trial = {rem_i, dvd_i[QW-1]};
  assign ge    = trial >= {1'b0, divisor_i};
  assign rem_d = ge ? 10'(trial - {1'b0, divisor_i}) : trial[9:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)
      valid_o <= 1'b0;
    else if (en_i)
      valid_o <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      dvd_o  <= {dvd_i[QW-2:0], 1'b0};
      quo_o  <= {quo_i[QW-2:0], ge};
      side_o <= side_i;
    end
  end

endmodule

// File: design/trpp_cordic_cell.sv
// One rotation-mode CORDIC micro-rotation cell, angles in units of 2^-32 turn.
module trpp_cordic_cell #(
  parameter int STEP = 0,
  parameter int SW   = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic signed [trpp_pkg::ZW-1:0] x_i,
  input  logic signed [trpp_pkg::ZW-1:0] y_i,
  input  logic signed [trpp_pkg::ZW-1:0] z_i,
  input  logic [SW-1:0]               side_i,
  output logic                        valid_o,
  output logic signed [trpp_pkg::ZW-1:0] x_o,
  output logic signed [trpp_pkg::ZW-1:0] y_o,
  output logic signed [trpp_pkg::ZW-1:0] z_o,
  output logic [SW-1:0]               side_o
);
  import trpp_pkg::*;

  localparam logic signed [ZW-1:0] ATAN = $signed({{(ZW-32){1'b0}}, atan_turns(STEP)});

  logic signed [ZW-1:0] xs, ys, x_d, y_d, z_d;

  // Rotate toward zero residual angle
  assign xs = x_i >>> STEP;
  assign ys = y_i >>> STEP;
  always_comb begin
    if (!z_i[ZW-1]) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)
      valid_o <= 1'b0;
    else if (en_i)
      valid_o <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o    <= x_d;
      y_o    <= y_d;
      z_o    <= z_d;
      side_o <= side_i;
    end
  end

endmodule
